>>> hw/rtl/mcsd_pkg.sv
`default_nettype none

package mcsd_pkg;

  localparam int GROUPS_DEF             = 3;
  localparam int CHANNELS_PER_GROUP_DEF = 8;
  localparam int MASK_BITS_DEF          = 32;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_TABLE_A = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TABLE_B = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TABLE_C = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SETUP_A = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SETUP_B = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SETUP_C = 3'd6;

  localparam int          NEG_SIDE_BIT = 7;
  localparam logic [7:0]  END_MARK     = 8'hff;
  localparam logic [3:0]  NOT_STARTED  = 4'hf;
  localparam int          POS_W        = 9;

  typedef struct packed {
    logic              take;
    logic              hi;
    logic [POS_W-1:0]  pos;
    logic [3:0]        next_ch;
    logic [31:0]       ctrl_word;
  } grp_step_t;

  function automatic logic [7:0] info_byte(input logic [63:0] tbl, input logic [2:0] idx);
    info_byte = tbl[{idx, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mcsd_group.sv
`default_nettype none

module mcsd_group #(
  parameter int CHANNELS_PER_GROUP = mcsd_pkg::CHANNELS_PER_GROUP_DEF,
  parameter int MASK_BITS          = mcsd_pkg::MASK_BITS_DEF
) (
  input  wire logic [63:0]         chan_table,
  input  wire logic [63:0]         setup_words,
  input  wire logic [7:0]          base,
  input  wire logic [3:0]          ch,
  input  wire logic                level,
  output mcsd_pkg::grp_step_t      step
);

  logic [7:0] cur_info;
  logic [7:0] nxt_info;
  logic [7:0] sel_info;
  logic [3:0] inc_ch;
  logic [3:0] next_ch;
  logic       started;

  always_comb begin
    started  = ch < 4'(CHANNELS_PER_GROUP);
    cur_info = mcsd_pkg::info_byte(chan_table, ch[2:0]);
    inc_ch   = ch + 4'd1;
    nxt_info = mcsd_pkg::info_byte(chan_table, inc_ch[2:0]);
    if (!started || inc_ch >= 4'(CHANNELS_PER_GROUP) || nxt_info == mcsd_pkg::END_MARK) begin
      next_ch = 4'd0;
    end else begin
      next_ch = inc_ch;
    end
    sel_info = mcsd_pkg::info_byte(chan_table, next_ch[2:0]);

    step.hi      = level ^ cur_info[mcsd_pkg::NEG_SIDE_BIT];
    step.pos     = mcsd_pkg::POS_W'(base) + mcsd_pkg::POS_W'(ch);
    // Samples landing past the top of the mask are dropped, but the scan moves on.
    step.take    = started && (step.pos < mcsd_pkg::POS_W'(MASK_BITS));
    step.next_ch = next_ch;
    if (sel_info[mcsd_pkg::NEG_SIDE_BIT]) begin
      step.ctrl_word = {20'd0, sel_info, 4'd0} | setup_words[63:32];
    end else begin
      step.ctrl_word = {24'd0, sel_info} | setup_words[31:0];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mcsd_debounce.sv
`default_nettype none

module mcsd_debounce #(
  parameter int MASK_BITS = mcsd_pkg::MASK_BITS_DEF
) (
  input  wire logic [MASK_BITS-1:0] prev_in,
  input  wire logic [MASK_BITS-1:0] stable_in,
  input  wire mcsd_pkg::grp_step_t  step,
  output logic      [MASK_BITS-1:0] prev_out,
  output logic      [MASK_BITS-1:0] stable_out
);

  localparam int IDX_W = (MASK_BITS > 1) ? $clog2(MASK_BITS) : 1;

  logic [IDX_W-1:0] idx;

  always_comb begin
    idx        = step.pos[IDX_W-1:0];
    prev_out   = prev_in;
    stable_out = stable_in;
    if (step.take) begin
      // Two equal samples in a row settle the state; otherwise remember the new one.
      if (prev_in[idx] == step.hi) begin
        stable_out[idx] = step.hi;
      end else begin
        prev_out[idx] = step.hi;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/multiplexed_comparator_scan_debounce_unit.sv
`default_nettype none

// Channel   Handshake           Payload
// --------  ------------------  ----------------------------------------------
// in        in_valid/in_stall   level_a, level_b, level_c
// out       out_valid/out_stall ctrl_word_a, ctrl_word_b, ctrl_word_c,
//                               debounced_mask
// cfg       cfg_we              cfg_index, cfg_data (write only)
//
// A request is taken into an input register; when the output is not stalled, one
// pass of per-group logic updates the scan state and loads the result register.
// out_valid rises with that load; one request per cycle while the output is not stalled.
// Synchronous reset puts every group in the not-started state and clears masks.
// A stalled result holds; the input register keeps accepting while it can drain.
module multiplexed_comparator_scan_debounce_unit #(
  parameter int GROUPS             = mcsd_pkg::GROUPS_DEF,
  parameter int CHANNELS_PER_GROUP = mcsd_pkg::CHANNELS_PER_GROUP_DEF,
  parameter int MASK_BITS          = mcsd_pkg::MASK_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [mcsd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [mcsd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                level_a,
  input  wire logic                                level_b,
  input  wire logic                                level_c,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [31:0]                              ctrl_word_a,
  output logic [31:0]                              ctrl_word_b,
  output logic [31:0]                              ctrl_word_c,
  output logic [31:0]                              debounced_mask
);

  logic [2:0][63:0]          chan_table;
  logic [2:0][63:0]          setup_words;
  logic [23:0]               base_bits;

  logic                      s1_valid;
  logic [2:0]                s1_level;
  logic                      advance;
  logic                      in_take;

  logic [2:0][3:0]           active_ch;
  logic [2:0][3:0]           active_ch_next;
  logic [MASK_BITS-1:0]      prev_mask;
  logic [MASK_BITS-1:0]      stable_mask;
  logic [3:0][MASK_BITS-1:0] prev_chain;
  logic [3:0][MASK_BITS-1:0] stable_chain;
  logic [2:0][31:0]          words_next;
  logic [2:0][31:0]          words;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_table  <= '0;
      setup_words <= '0;
      base_bits   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mcsd_pkg::REG_TABLE_A: chan_table[0]  <= cfg_data;
        mcsd_pkg::REG_TABLE_B: chan_table[1]  <= cfg_data;
        mcsd_pkg::REG_TABLE_C: chan_table[2]  <= cfg_data;
        mcsd_pkg::REG_BASE:    base_bits      <= cfg_data[23:0];
        mcsd_pkg::REG_SETUP_A: setup_words[0] <= cfg_data;
        mcsd_pkg::REG_SETUP_B: setup_words[1] <= cfg_data;
        mcsd_pkg::REG_SETUP_C: setup_words[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign prev_chain[0]   = prev_mask;
  assign stable_chain[0] = stable_mask;

  // Groups are applied in order, so a later group sees bits an earlier one just wrote.
  for (genvar g = 0; g < 3; g++) begin : g_grp
    if (g < GROUPS) begin : g_used
      mcsd_pkg::grp_step_t step;

      mcsd_group #(
        .CHANNELS_PER_GROUP(CHANNELS_PER_GROUP),
        .MASK_BITS(MASK_BITS)
      ) u_group (
        .chan_table (chan_table[g]),
        .setup_words(setup_words[g]),
        .base       (base_bits[g*8 +: 8]),
        .ch         (active_ch[g]),
        .level      (s1_level[g]),
        .step       (step)
      );

      mcsd_debounce #(
        .MASK_BITS(MASK_BITS)
      ) u_debounce (
        .prev_in   (prev_chain[g]),
        .stable_in (stable_chain[g]),
        .step      (step),
        .prev_out  (prev_chain[g+1]),
        .stable_out(stable_chain[g+1])
      );

      assign active_ch_next[g] = step.next_ch;
      assign words_next[g]     = step.ctrl_word;
    end else begin : g_unused
      assign prev_chain[g+1]   = prev_chain[g];
      assign stable_chain[g+1] = stable_chain[g];
      assign active_ch_next[g] = active_ch[g];
      assign words_next[g]     = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      active_ch   <= {3{mcsd_pkg::NOT_STARTED}};
      prev_mask   <= '0;
      stable_mask <= '0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid   <= 1'b1;
        active_ch   <= active_ch_next;
        prev_mask   <= prev_chain[3];
        stable_mask <= stable_chain[3];
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_level <= {level_c, level_b, level_a};
    end
    if (advance) begin
      words <= words_next;
    end
  end

  assign ctrl_word_a    = words[0];
  assign ctrl_word_b    = words[1];
  assign ctrl_word_c    = words[2];
  assign debounced_mask = 32'(stable_mask);

endmodule

`default_nettype wire
